### rtl/ckps_pkg.sv
// ----------------------------------------------------------------------------
// ckps_pkg
// Shared types, constants and blend function for the color-keyed 3x scaler.
// ----------------------------------------------------------------------------
package ckps_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int CHANNEL_COUNT = 4;
  localparam int PIX_W         = 32;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int GRID_CELLS    = 9;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_COLOR  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_MODE = 1'd1;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_MID   = 2'd1;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_VPAIR  = 2'd1,
    MODE_HPAIR  = 2'd2,
    MODE_QUAD   = 2'd3
  } mode_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [GRID_CELLS-1:0] grid_t;

  typedef struct packed {
    pix_t top_left;
    pix_t top_right;
    pix_t bottom_left;
    pix_t bottom_right;
  } in_req_t;

  typedef struct packed {
    logic [1:0] row_index;
    pix_t       left_pixel;
    pix_t       middle_pixel;
    pix_t       right_pixel;
    logic [2:0] write_mask;
    logic       last_row;
  } out_req_t;

  // per-channel floor average; bits above the channels stay zero
  function automatic pix_t chan_avg(input pix_t a, input pix_t b);
    pix_t                res;
    logic [CHANNEL_BITS:0] sum;
    res = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      sum = {1'b0, a[c*CHANNEL_BITS +: CHANNEL_BITS]}
          + {1'b0, b[c*CHANNEL_BITS +: CHANNEL_BITS]};
      res[c*CHANNEL_BITS +: CHANNEL_BITS] = sum[CHANNEL_BITS:1];
    end
    return res;
  endfunction

  function automatic pix_t key_blend(input pix_t a, input pix_t b, input pix_t key);
    pix_t res;
    if (a == key) begin
      res = b;
    end else if (b == key) begin
      res = a;
    end else begin
      res = chan_avg(a, b);
    end
    return res;
  endfunction

endpackage

### rtl/ckps_edge_stage.sv
// ----------------------------------------------------------------------------
// ckps_edge_stage
// Builds the 3x3 grid from the source group; 2x2: corners and edge blends.
// ----------------------------------------------------------------------------
module ckps_edge_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  ckps_pkg::in_req_t up_data,
  input  ckps_pkg::mode_t  mode,
  input  ckps_pkg::pix_t   key,
  output logic             dn_valid,
  input  logic             dn_ready,
  output ckps_pkg::grid_t  dn_grid,
  output logic             dn_quad
);
  import ckps_pkg::*;

  logic  valid_r;
  grid_t grid_r, grid_nxt;
  logic  quad_r;
  pix_t  c0, c1, c2, c3;
  pix_t  mid_v, mid_h, top, lft, rgt, bot;

  assign c0 = up_data.top_left;
  assign c1 = up_data.top_right;
  assign c2 = up_data.bottom_left;
  assign c3 = up_data.bottom_right;

  assign mid_v = key_blend(c0, c2, key);
  assign mid_h = key_blend(c0, c1, key);
  assign top   = mid_h;
  assign lft   = mid_v;
  assign rgt   = key_blend(c1, c3, key);
  assign bot   = key_blend(c2, c3, key);

  always_comb begin
    case (mode)
      MODE_SINGLE: begin
        for (int i = 0; i < GRID_CELLS; i++) grid_nxt[i] = c0;
      end
      MODE_VPAIR: begin
        grid_nxt[0] = c0;    grid_nxt[1] = c0;    grid_nxt[2] = c0;
        grid_nxt[3] = mid_v; grid_nxt[4] = mid_v; grid_nxt[5] = mid_v;
        grid_nxt[6] = c2;    grid_nxt[7] = c2;    grid_nxt[8] = c2;
      end
      MODE_HPAIR: begin
        for (int r = 0; r < 3; r++) begin
          grid_nxt[r*3]   = c0;
          grid_nxt[r*3+1] = mid_h;
          grid_nxt[r*3+2] = c1;
        end
      end
      default: begin
        // center is filled in by the next stage
        grid_nxt[0] = c0;  grid_nxt[1] = top; grid_nxt[2] = c1;
        grid_nxt[3] = lft; grid_nxt[4] = top; grid_nxt[5] = rgt;
        grid_nxt[6] = c2;  grid_nxt[7] = bot; grid_nxt[8] = c3;
      end
    endcase
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      grid_r <= grid_nxt;
      quad_r <= (mode == MODE_QUAD);
    end
  end

  assign dn_valid = valid_r;
  assign dn_grid  = grid_r;
  assign dn_quad  = quad_r;

endmodule

### rtl/ckps_center_stage.sv
// ----------------------------------------------------------------------------
// ckps_center_stage
// Blends the center cell from the top and bottom edge pixels in 2x2 mode.
// ----------------------------------------------------------------------------
module ckps_center_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  ckps_pkg::grid_t up_grid,
  input  logic            up_quad,
  input  ckps_pkg::pix_t  key,
  output logic            dn_valid,
  input  logic            dn_ready,
  output ckps_pkg::grid_t dn_grid
);
  import ckps_pkg::*;

  logic  valid_r;
  grid_t grid_r, grid_nxt;

  always_comb begin
    grid_nxt = up_grid;
    if (up_quad) begin
      grid_nxt[4] = key_blend(up_grid[1], up_grid[7], key);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      grid_r <= grid_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_grid  = grid_r;

endmodule

### rtl/ckps_row_serializer.sv
// ----------------------------------------------------------------------------
// ckps_row_serializer
// Holds one finished 3x3 block and sends it out one row per request.
// ----------------------------------------------------------------------------
module ckps_row_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  ckps_pkg::grid_t   up_grid,
  input  ckps_pkg::pix_t    key,
  output logic              out_valid,
  input  logic              out_ready,
  output ckps_pkg::out_req_t out_data
);
  import ckps_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] row_r, row_nxt;
  grid_t      grid_r;
  logic       last;
  logic       fire;
  logic       load;
  pix_t       p0, p1, p2;

  assign last     = (row_r == ROW_LAST);
  assign fire     = valid_r && out_ready;
  // a new block may load on the edge the last row leaves
  assign up_ready = !valid_r || (out_ready && last);
  assign load     = up_valid && up_ready;

  always_comb begin
    valid_nxt = valid_r;
    row_nxt   = row_r;
    if (load) begin
      valid_nxt = 1'b1;
      row_nxt   = ROW_FIRST;
    end else if (fire) begin
      valid_nxt = !last;
      row_nxt   = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      row_r   <= ROW_FIRST;
    end else begin
      valid_r <= valid_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grid_r <= up_grid;
    end
  end

  always_comb begin
    case (row_r)
      ROW_FIRST: begin
        p0 = grid_r[0]; p1 = grid_r[1]; p2 = grid_r[2];
      end
      ROW_MID: begin
        p0 = grid_r[3]; p1 = grid_r[4]; p2 = grid_r[5];
      end
      default: begin
        p0 = grid_r[6]; p1 = grid_r[7]; p2 = grid_r[8];
      end
    endcase
  end

  assign out_valid              = valid_r;
  assign out_data.row_index     = row_r;
  assign out_data.left_pixel    = p0;
  assign out_data.middle_pixel  = p1;
  assign out_data.right_pixel   = p2;
  assign out_data.write_mask    = {p2 != key, p1 != key, p0 != key};
  assign out_data.last_row      = last;

endmodule

### rtl/color_keyed_3x_pixel_scaler.sv
// ----------------------------------------------------------------------------
// color_keyed_3x_pixel_scaler
// Grows a source pixel group to a 3x3 block with key-aware blending.
// ----------------------------------------------------------------------------
// 4 stages: input, edge, center, rows. A block's first row is shown once its
//   request has passed all four. The row serializer sends one destination row
//   per cycle while not stalled; the next block loads as the last row leaves.
// Reset (synchronous, rst_n low): pipeline empty, key_color = 0,
//   scale_mode = 2x2.
// ----------------------------------------------------------------------------
module color_keyed_3x_pixel_scaler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ckps_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ckps_pkg::out_req_t                  out_data,
  input  logic                                cfg_we,
  input  logic [ckps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ckps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ckps_pkg::*;

  pix_t    key_r;
  mode_t   mode_r;
  logic    s1_valid_r;
  in_req_t s1_data_r;
  logic    s1_ready;
  logic    s2_valid, s2_ready, s2_quad;
  grid_t   s2_grid;
  logic    s3_valid, s3_ready;
  grid_t   s3_grid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mode_r <= MODE_QUAD;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_COLOR:  key_r  <= cfg_wdata[PIX_W-1:0];
        REG_SCALE_MODE: mode_r <= mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // input register stage
  assign in_ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  ckps_edge_stage u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid_r),
    .up_ready (s1_ready),
    .up_data  (s1_data_r),
    .mode     (mode_r),
    .key      (key_r),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_grid  (s2_grid),
    .dn_quad  (s2_quad)
  );

  ckps_center_stage u_center (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_grid  (s2_grid),
    .up_quad  (s2_quad),
    .key      (key_r),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_grid  (s3_grid)
  );

  ckps_row_serializer u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s3_valid),
    .up_ready  (s3_ready),
    .up_grid   (s3_grid),
    .key       (key_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/ckps_checker.sv
// ----------------------------------------------------------------------------
// ckps_checker
// Port-level checks on the result row stream of the scaler.
// ----------------------------------------------------------------------------
module ckps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input ckps_pkg::out_req_t out_data
);
  import ckps_pkg::*;

  // stalled row holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result row changed while stalled");

  // rows of one block follow without a gap, in order
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.row_index != ROW_LAST |=>
      out_valid && out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row sequence broken");

  // last_row flags row 2 only, row 3 never appears
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row_index != 2'd3 &&
      out_data.last_row == (out_data.row_index == ROW_LAST))
    else $error("last_row or row_index inconsistent");

  // a block that starts after an idle gap begins at row 0
  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_data.row_index == ROW_FIRST)
    else $error("block did not start at row 0");

endmodule

bind color_keyed_3x_pixel_scaler ckps_checker u_ckps_checker (.*);
